@@ src/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// sat_pkg
// Shared widths, mode codes and chain types for the segment address
// translator.
// ----------------------------------------------------------------------------
package sat_pkg;

   localparam int ADDR_W               = 64;
   localparam int MODE_W               = 2;
   localparam int COUNT_W              = 5;
   localparam int SEG_IDX_W            = 4;
   localparam int HIT_W                = 4;
   localparam int DEFAULT_MAX_SEGMENTS = 16;

   // request tdata: address, length, fatal_on_miss, seg_index, vm, file, size
   localparam int REQ_FIELDS_W = 4 * ADDR_W + 1 + SEG_IDX_W + ADDR_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   // response tdata: found, translated, room, hit_segment, fatal
   localparam int RSP_FIELDS_W = 1 + 2 * ADDR_W + HIT_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [MODE_W-1:0] MODE_V2F   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_F2V   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

   // query token walking down the cell chain
   typedef struct packed {
      logic              valid;
      logic              xlate;
      logic              from_file;
      logic [ADDR_W-1:0] address;
   } query_type;

   // candidate hit carried along the chain
   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] other;
      logic [ADDR_W-1:0] size;
   } rec_type;

endpackage

@@ src/sat_cell.sv @@
// ----------------------------------------------------------------------------
// sat_cell
// One segment table entry plus one chain stage: probes the passing query
// against its entry and forwards the first-hit and last-hit candidates.
// ----------------------------------------------------------------------------
module sat_cell import sat_pkg::*; #(
   parameter int MAX_SEGMENTS = DEFAULT_MAX_SEGMENTS,
   parameter int INDEX        = 0,
   localparam int IDX_W       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_vm,
   input  logic [ADDR_W-1:0]     wr_file,
   input  logic [ADDR_W-1:0]     wr_size,
   input  logic                  enable,
   input  logic                  lh_select,
   input  query_type             q_in,
   input  rec_type               scan_in,
   input  logic [IDX_W-1:0]      scan_idx_in,
   input  rec_type               lh_in,
   output query_type             q_out,
   output rec_type               scan_out,
   output logic [IDX_W-1:0]      scan_idx_out,
   output rec_type               lh_out
);

   logic [ADDR_W-1:0] vm_ff, file_ff, size_ff;
   logic              q_valid_ff, q_valid_in;
   query_type         q_ff;
   rec_type           scan_ff, scan_in_nx, lh_ff, lh_in_nx;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in_nx;
   logic [ADDR_W-1:0] base, other, off;
   logic              hit;

   // entry storage, loaded by write items
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vm_ff   <= wr_vm;
         file_ff <= wr_file;
         size_ff <= wr_size;
      end
   end

   // probe: offset from start, unsigned so addresses below start miss
   always_comb begin
      base  = q_in.from_file ? file_ff : vm_ff;
      other = q_in.from_file ? vm_ff : file_ff;
      off   = q_in.address - base;
      hit   = q_in.valid && q_in.xlate && enable && (off < size_ff);
   end

   // candidate update: keep the earliest scan hit, take the last-hit probe
   always_comb begin
      scan_in_nx     = scan_in;
      scan_idx_in_nx = scan_idx_in;
      lh_in_nx       = lh_in;
      if (!scan_in.hit && hit) begin
         scan_in_nx     = '{hit: 1'b1, off: off, other: other, size: size_ff};
         scan_idx_in_nx = IDX_W'(INDEX);
      end
      if (lh_select && hit) begin
         lh_in_nx = '{hit: 1'b1, off: off, other: other, size: size_ff};
      end
      q_valid_in = q_in.valid;
   end

   // chain stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      scan_ff     <= scan_in_nx;
      scan_idx_ff <= scan_idx_in_nx;
      lh_ff       <= lh_in_nx;
   end

   always_comb begin
      q_out       = q_ff;
      q_out.valid = q_valid_ff;
   end
   assign scan_out     = scan_ff;
   assign scan_idx_out = scan_idx_ff;
   assign lh_out       = lh_ff;

endmodule

@@ src/sat_finish.sv @@
// ----------------------------------------------------------------------------
// sat_finish
// End of the cell chain: picks the last-hit or first scan hit, forms the
// translated address and room, checks the length and holds the response.
// ----------------------------------------------------------------------------
module sat_finish import sat_pkg::*; #(
   parameter int MAX_SEGMENTS = DEFAULT_MAX_SEGMENTS,
   localparam int IDX_W       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  query_type             q_end,
   input  rec_type               scan_end,
   input  logic [IDX_W-1:0]      scan_idx_end,
   input  rec_type               lh_end,
   input  logic [IDX_W-1:0]      last_hit,
   input  logic [ADDR_W-1:0]     length,
   input  logic                  fatal_on_miss,
   output logic                  upd_valid,
   output logic [IDX_W-1:0]      upd_idx,
   output logic                  done,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   rec_type           sel;
   logic [IDX_W-1:0]  sel_idx;
   logic              sel_hit;

   logic              a_valid_ff, a_valid_in;
   logic              a_hit_ff, a_xlate_ff;
   logic [IDX_W-1:0]  a_idx_ff;
   logic [ADDR_W-1:0] a_xlat_ff, a_left_ff;

   logic              b_valid_ff, b_valid_in;
   logic              b_found_ff, b_fatal_ff, b_found;
   logic [ADDR_W-1:0] b_xlat_ff, b_room_ff;
   logic [HIT_W-1:0]  b_hit_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // selection: a last-hit probe that hit wins over the scan
   always_comb begin
      sel     = lh_end.hit ? lh_end : scan_end;
      sel_idx = lh_end.hit ? last_hit : scan_idx_end;
      sel_hit = q_end.valid && (lh_end.hit || scan_end.hit);
   end

   assign upd_valid = sel_hit;
   assign upd_idx   = sel_idx;

   // stage A: translated address and room
   assign a_valid_in = q_end.valid;

   always_ff @(posedge clock) begin
      a_hit_ff   <= sel_hit;
      a_xlate_ff <= q_end.xlate;
      a_idx_ff   <= sel_idx;
      a_xlat_ff  <= sel.other + sel.off;
      a_left_ff  <= sel.size - sel.off;
   end

   // stage B: length check and result fields, held until the output frees
   assign b_found = a_hit_ff && (length <= a_left_ff);
   assign done    = b_valid_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      b_valid_in = b_valid_ff;
      if (a_valid_ff) begin
         b_valid_in = 1'b1;
      end else if (done) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         b_found_ff <= b_found;
         b_fatal_ff <= a_xlate_ff && !b_found && fatal_on_miss;
         b_xlat_ff  <= b_found ? a_xlat_ff : '0;
         b_room_ff  <= b_found ? a_left_ff : '0;
         b_hit_ff   <= b_found ? HIT_W'(a_idx_ff) : '0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= RSP_DATA_W'({b_fatal_ff, b_hit_ff, b_room_ff, b_xlat_ff,
                                     b_found_ff});
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ src/segment_address_translator_core.sv @@
// ----------------------------------------------------------------------------
// segment_address_translator_core
// Segment table address translation over a chain of per-entry cells.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata fields, tuser mode
//   rsp      out        rsp_tvalid/rsp_tready  tdata result fields
//   csr      in         csr_wr_en              csr_wr_data segment_count
//
// Every item (translate, write or unused mode) walks the whole chain:
// MAX_SEGMENTS cell stages plus two finish stages. One item is in flight
// at a time; the next is taken once the previous result has moved into
// the output register. A stalled response holds the finished item in the
// last finish stage. Reset clears last hit, segment count and valids;
// table entries are undefined until written.
// ----------------------------------------------------------------------------
module segment_address_translator_core import sat_pkg::*; #(
   parameter int MAX_SEGMENTS = DEFAULT_MAX_SEGMENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   // address[63:0], length[127:64], fatal_on_miss[128], seg_index[132:129],
   // entry_vm_start[196:133], entry_file_start[260:197],
   // entry_size[324:261], zero pad above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [MODE_W-1:0]     req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // found[0], translated[64:1], room[128:65], hit_segment[132:129],
   // fatal[133], zero pad above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_wr_en,
   input  logic [COUNT_W-1:0]    csr_wr_data
);

   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

   logic                  busy_ff, busy_in;
   logic [COUNT_W-1:0]    segment_count_ff;
   logic [IDX_W-1:0]      last_hit_ff;
   logic [ADDR_W-1:0]     length_ff;
   logic                  fatal_on_miss_ff;
   logic                  accept, is_write, done, upd_valid;
   logic [IDX_W-1:0]      upd_idx;

   logic [ADDR_W-1:0]     in_address, in_length, in_vm, in_file, in_size;
   logic                  in_fatal_on_miss;
   logic [SEG_IDX_W-1:0]  in_seg_index;

   logic [MAX_SEGMENTS-1:0] enable, lh_select, wr_en;
   query_type               q_chain        [MAX_SEGMENTS+1];
   rec_type                 scan_chain     [MAX_SEGMENTS+1];
   rec_type                 lh_chain       [MAX_SEGMENTS+1];
   logic [IDX_W-1:0]        scan_idx_chain [MAX_SEGMENTS+1];

   // request unpacking
   assign in_address       = req_tdata[63:0];
   assign in_length        = req_tdata[127:64];
   assign in_fatal_on_miss = req_tdata[128];
   assign in_seg_index     = req_tdata[132:129];
   assign in_vm            = req_tdata[196:133];
   assign in_file          = req_tdata[260:197];
   assign in_size          = req_tdata[324:261];

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign is_write   = (req_tuser == MODE_WRITE);

   // busy from accept until the result reaches the output register
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         segment_count_ff <= '0;
         last_hit_ff      <= '0;
      end else begin
         busy_ff <= busy_in;
         if (csr_wr_en) begin
            segment_count_ff <= csr_wr_data;
         end
         if (upd_valid) begin
            last_hit_ff <= upd_idx;
         end
      end
   end

   // per-item operands held for the finish stages
   always_ff @(posedge clock) begin
      if (accept) begin
         length_ff        <= in_length;
         fatal_on_miss_ff <= in_fatal_on_miss;
      end
   end

   // chain head
   always_comb begin
      q_chain[0].valid     = accept;
      q_chain[0].xlate     = (req_tuser == MODE_V2F) || (req_tuser == MODE_F2V);
      q_chain[0].from_file = (req_tuser == MODE_F2V);
      q_chain[0].address   = in_address;
      scan_chain[0]        = '0;
      lh_chain[0]          = '0;
      scan_idx_chain[0]    = '0;
   end

   // cells: entries in use, last-hit probe position, write strobes
   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
      assign enable[i]    = (32'(i) < 32'(segment_count_ff));
      assign lh_select[i] = enable[i] && (last_hit_ff == IDX_W'(i));
      assign wr_en[i]     = accept && is_write && (32'(in_seg_index) == 32'(i));

      sat_cell #(
         .MAX_SEGMENTS (MAX_SEGMENTS),
         .INDEX        (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .wr_en        (wr_en[i]),
         .wr_vm        (in_vm),
         .wr_file      (in_file),
         .wr_size      (in_size),
         .enable       (enable[i]),
         .lh_select    (lh_select[i]),
         .q_in         (q_chain[i]),
         .scan_in      (scan_chain[i]),
         .scan_idx_in  (scan_idx_chain[i]),
         .lh_in        (lh_chain[i]),
         .q_out        (q_chain[i+1]),
         .scan_out     (scan_chain[i+1]),
         .scan_idx_out (scan_idx_chain[i+1]),
         .lh_out       (lh_chain[i+1])
      );
   end

   // chain tail
   sat_finish #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_finish (
      .clock         (clock),
      .reset         (reset),
      .q_end         (q_chain[MAX_SEGMENTS]),
      .scan_end      (scan_chain[MAX_SEGMENTS]),
      .scan_idx_end  (scan_idx_chain[MAX_SEGMENTS]),
      .lh_end        (lh_chain[MAX_SEGMENTS]),
      .last_hit      (last_hit_ff),
      .length        (length_ff),
      .fatal_on_miss (fatal_on_miss_ff),
      .upd_valid     (upd_valid),
      .upd_idx       (upd_idx),
      .done          (done),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule
